@@ rtl/i2cbb_pkg.sv @@
package i2cbb_pkg;

  // Bus commands; the idle code doubles as "no command running".
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Phase code that a new command starts in.
  localparam logic [2:0] PhaseFirst = 3'd1;

  // Number of data bits in one byte transfer.
  localparam logic [3:0] BitsPerByte = 4'd8;

  // Complete sequencer state, updated once per tick.
  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] phase;
    logic [3:0] bit_count;
    logic [7:0] shift;
    logic       nack;
    logic       scl;
    logic       sda_drive;
    logic [7:0] rx_hold;
    logic       ack_hold;
  } seq_state_t;

  // Sequencer state after reset: SCL high, SDA released.
  localparam seq_state_t SeqReset = '{
    cmd:       CMD_IDLE,
    phase:     3'd0,
    bit_count: 4'd0,
    shift:     8'd0,
    nack:      1'b0,
    scl:       1'b1,
    sda_drive: 1'b0,
    rx_hold:   8'd0,
    ack_hold:  1'b0
  };

endpackage

@@ rtl/i2c_bitbang_master_core.sv @@
// Channel | Handshake               | Payload
// --------+-------------------------+------------------------------------------------
// in      | in_valid_i / in_stall_o | op_i, tx_byte_i, last_byte_i, sda_in_i
// out     | out_valid_o/out_stall_i | scl_o, sda_low_o, busy_res_o, done_res_o,
//         |                         | rx_byte_o, acked_o
//
// One beat in gives one beat out; a beat can be taken in every cycle while the output is not stalled.
// A result passes through the input register, then the sequencer step into the result
// register.
// Reset clears the sequencer to idle with SCL high and SDA released.
// A stall on a valid output holds the result register and, once the input register is
// full, raises in_stall_o in the same cycle.
module i2c_bitbang_master_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic [7:0] tx_byte_i,
  input  logic       last_byte_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_o,
  output logic       sda_low_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       acked_o
);
  import i2cbb_pkg::*;

  logic       in_valid_q;
  logic [2:0] op_q;
  logic [7:0] tx_byte_q;
  logic       last_byte_q;
  logic       sda_in_q;

  seq_state_t state_q;
  seq_state_t state_d;
  logic       step_done;
  logic       step_fire;
  logic       in_take;

  logic       out_valid_q;
  logic       scl_q;
  logic       sda_low_q;
  logic       busy_q;
  logic       done_q;
  logic [7:0] rx_byte_q;
  logic       acked_q;

  // The step runs when the input register is full and the result register can take it.
  assign step_fire  = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q        <= op_i;
      tx_byte_q   <= tx_byte_i;
      last_byte_q <= last_byte_i;
      sda_in_q    <= sda_in_i;
    end
  end

  // Sequencer step logic.
  i2cbb_step u_step (
    .state_i     (state_q),
    .op_i        (op_q),
    .tx_byte_i   (tx_byte_q),
    .last_byte_i (last_byte_q),
    .sda_in_i    (sda_in_q),
    .state_o     (state_d),
    .done_o      (step_done)
  );

  // Sequencer state advances once per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqReset;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      scl_q     <= state_d.scl;
      sda_low_q <= state_d.sda_drive;
      busy_q    <= (state_d.cmd != CMD_IDLE);
      done_q    <= step_done;
      rx_byte_q <= state_d.rx_hold;
      acked_q   <= state_d.ack_hold;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = scl_q;
  assign sda_low_o   = sda_low_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_byte_q;
  assign acked_o     = acked_q;

  // An idle sequencer always sits at phase zero with a cleared bit count.
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.cmd == CMD_IDLE) |-> (state_q.phase == 3'd0 && state_q.bit_count == 4'd0))
    else $error("idle sequencer has stale phase or bit count");

  // The bit count never passes one byte.
  a_bit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_count <= BitsPerByte)
    else $error("bit count out of range");

  // A finishing step leaves the sequencer idle.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && step_done) |=> (state_q.cmd == CMD_IDLE))
    else $error("sequencer not idle after done");

  // A reported completion never comes with busy.
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> !busy_q)
    else $error("done and busy reported together");

  // Without a step, the sequencer state holds.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(state_q))
    else $error("sequencer state moved without a beat");

endmodule

@@ rtl/i2cbb_step.sv @@
module i2cbb_step (
  input  i2cbb_pkg::seq_state_t state_i,
  input  logic [2:0]            op_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  last_byte_i,
  input  logic                  sda_in_i,
  output i2cbb_pkg::seq_state_t state_o,
  output logic                  done_o
);
  import i2cbb_pkg::*;

  logic [3:0] bc_inc;

  assign bc_inc = state_i.bit_count + 4'd1;

  // One bus phase per tick: launch a new command when idle (other ops are ignored) or advance the running one.
  always_comb begin
    state_o = state_i;
    done_o  = 1'b0;
    unique case (state_i.cmd)
      CMD_IDLE: begin
        case (op_i) inside
          CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: begin
            state_o.cmd       = cmd_e'(op_i);
            state_o.phase     = PhaseFirst;
            state_o.bit_count = 4'd0;
            state_o.scl       = 1'b0;
            if (op_i == CMD_WRITE) begin
              state_o.shift = tx_byte_i;
            end
            if (op_i == CMD_READ) begin
              state_o.shift = 8'd0;
              state_o.nack  = last_byte_i;
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        case (state_i.phase)
          3'd1: begin
            state_o.sda_drive = 1'b0;
            state_o.phase     = 3'd2;
          end
          3'd2: begin
            state_o.scl   = 1'b1;
            state_o.phase = 3'd3;
          end
          default: begin
            state_o.sda_drive = 1'b1;
            done_o            = 1'b1;
          end
        endcase
      end
      CMD_STOP: begin
        case (state_i.phase)
          3'd1: begin
            state_o.sda_drive = 1'b1;
            state_o.phase     = 3'd2;
          end
          3'd2: begin
            state_o.scl   = 1'b1;
            state_o.phase = 3'd3;
          end
          default: begin
            state_o.sda_drive = 1'b0;
            done_o            = 1'b1;
          end
        endcase
      end
      CMD_WRITE: begin
        case (state_i.phase)
          3'd1: begin
            state_o.sda_drive = ~state_i.shift[7];
            state_o.phase     = 3'd2;
          end
          3'd2: begin
            state_o.scl   = 1'b1;
            state_o.phase = 3'd3;
          end
          3'd3: begin
            state_o.scl       = 1'b0;
            state_o.shift     = {state_i.shift[6:0], 1'b0};
            state_o.bit_count = bc_inc;
            state_o.phase     = (bc_inc >= BitsPerByte) ? 3'd4 : 3'd1;
          end
          3'd4: begin
            state_o.sda_drive = 1'b0;
            state_o.phase     = 3'd5;
          end
          3'd5: begin
            state_o.scl      = 1'b1;
            state_o.ack_hold = ~sda_in_i;
            state_o.phase    = 3'd6;
          end
          default: begin
            state_o.scl = 1'b0;
            done_o      = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        case (state_i.phase)
          3'd1: begin
            state_o.sda_drive = 1'b0;
            state_o.phase     = 3'd2;
          end
          3'd2: begin
            state_o.scl   = 1'b1;
            state_o.shift = {state_i.shift[6:0], sda_in_i};
            state_o.phase = 3'd3;
          end
          3'd3: begin
            state_o.scl       = 1'b0;
            state_o.bit_count = bc_inc;
            state_o.phase     = (bc_inc >= BitsPerByte) ? 3'd4 : 3'd2;
          end
          3'd4: begin
            state_o.sda_drive = ~state_i.nack;
            state_o.phase     = 3'd5;
          end
          3'd5: begin
            state_o.scl   = 1'b1;
            state_o.phase = 3'd6;
          end
          3'd6: begin
            state_o.scl = 1'b0;
            if (state_i.nack) begin
              state_o.rx_hold = state_i.shift;
              done_o          = 1'b1;
            end else begin
              state_o.phase = 3'd7;
            end
          end
          default: begin
            state_o.sda_drive = 1'b0;
            state_o.rx_hold   = state_i.shift;
            done_o            = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    // A finished command returns the sequencer to idle.
    if (done_o) begin
      state_o.cmd       = CMD_IDLE;
      state_o.phase     = 3'd0;
      state_o.bit_count = 4'd0;
    end
  end

endmodule

@@ tb/sv/tb_i2c_bitbang_master_core.sv @@
`timescale 1ns / 100ps

module tb_i2c_bitbang_master_core;
  import i2cbb_pkg::*;

  // Ops above the last command are spares that an idle sequencer ignores.
  localparam logic [2:0] OpSpareLo  = 3'd5;
  localparam logic [2:0] OpSpareMid = 3'd6;
  localparam logic [2:0] OpSpareHi  = 3'd7;

  localparam int RandomBeats  = 1000;
  localparam int HoldCycles   = 80;
  localparam int DrainCycles  = 20;
  localparam int ShownMisses  = 10;

  // One result beat as the block presents it.
  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
  } pin_result_t;

  // Sequencer state kept by the predictor.
  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] phase;
    logic [3:0] bits;
    logic [7:0] shift;
    logic       nack;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
  } bus_seq_t;

  // One row of the directed part; the row repeats its beat reps times.
  typedef struct {
    logic [2:0]  op;
    logic [7:0]  tx;
    logic        last;
    logic        sda;
    int          reps;
    bit          typed;
    pin_result_t want;
  } stim_row_t;

  localparam pin_result_t PinsIdleReset = '{scl: 1'b1, sda_low: 1'b0, busy: 1'b0,
                                            done: 1'b0, rx: 8'h00, ack: 1'b0};
  localparam pin_result_t PinsStartDone = '{scl: 1'b1, sda_low: 1'b1, busy: 1'b0,
                                            done: 1'b1, rx: 8'h00, ack: 1'b0};
  localparam pin_result_t NoPins = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] op_i = CMD_IDLE;
  logic [7:0] tx_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       sda_in_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       scl_o;
  logic       sda_low_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;
  logic       acked_o;

  bus_seq_t    bus_seq;
  pin_result_t expected_pins[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  i2c_bitbang_master_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .tx_byte_i   (tx_byte_i),
    .last_byte_i (last_byte_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_o       (scl_o),
    .sda_low_o   (sda_low_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .acked_o     (acked_o)
  );

  always #10 clk_i = ~clk_i;

  // Advance the bus sequencer by one tick and return the pins it shows.
  function automatic pin_result_t step_bus(input logic [2:0] op, input logic [7:0] tx,
                                           input logic last, input logic sda_in);
    logic        fin;
    pin_result_t pins;
    fin = 1'b0;
    if (bus_seq.cmd == CMD_IDLE) begin
      // A new command is taken only while idle; spare ops fall through.
      if (op >= CMD_START && op <= CMD_READ) begin
        bus_seq.cmd   = cmd_e'(op);
        bus_seq.phase = 3'd1;
        bus_seq.bits  = 4'd0;
        bus_seq.scl   = 1'b0;
        if (op == CMD_WRITE) bus_seq.shift = tx;
        if (op == CMD_READ) begin
          bus_seq.shift = 8'h00;
          bus_seq.nack  = last;
        end
      end
    end else begin
      case (bus_seq.cmd)
        CMD_START, CMD_STOP: begin
          // Start releases SDA before SCL rises and then pulls it low; stop is the mirror.
          case (bus_seq.phase)
            3'd1: begin
              bus_seq.sda   = (bus_seq.cmd == CMD_STOP);
              bus_seq.phase = 3'd2;
            end
            3'd2: begin
              bus_seq.scl   = 1'b1;
              bus_seq.phase = 3'd3;
            end
            default: begin
              bus_seq.sda = (bus_seq.cmd == CMD_START);
              fin         = 1'b1;
            end
          endcase
        end
        CMD_WRITE: begin
          case (bus_seq.phase)
            3'd1: begin
              bus_seq.sda   = ~bus_seq.shift[7];
              bus_seq.phase = 3'd2;
            end
            3'd2: begin
              bus_seq.scl   = 1'b1;
              bus_seq.phase = 3'd3;
            end
            3'd3: begin
              bus_seq.scl   = 1'b0;
              bus_seq.shift = {bus_seq.shift[6:0], 1'b0};
              bus_seq.bits  = bus_seq.bits + 4'd1;
              bus_seq.phase = (bus_seq.bits >= 4'd8) ? 3'd4 : 3'd1;
            end
            3'd4: begin
              bus_seq.sda   = 1'b0;
              bus_seq.phase = 3'd5;
            end
            3'd5: begin
              // The slave acknowledges by holding SDA low.
              bus_seq.scl   = 1'b1;
              bus_seq.ack   = ~sda_in;
              bus_seq.phase = 3'd6;
            end
            default: begin
              bus_seq.scl = 1'b0;
              fin         = 1'b1;
            end
          endcase
        end
        default: begin
          case (bus_seq.phase)
            3'd1: begin
              bus_seq.sda   = 1'b0;
              bus_seq.phase = 3'd2;
            end
            3'd2: begin
              bus_seq.scl   = 1'b1;
              bus_seq.shift = {bus_seq.shift[6:0], sda_in};
              bus_seq.phase = 3'd3;
            end
            3'd3: begin
              bus_seq.scl   = 1'b0;
              bus_seq.bits  = bus_seq.bits + 4'd1;
              bus_seq.phase = (bus_seq.bits >= 4'd8) ? 3'd4 : 3'd2;
            end
            3'd4: begin
              bus_seq.sda   = ~bus_seq.nack;
              bus_seq.phase = 3'd5;
            end
            3'd5: begin
              bus_seq.scl   = 1'b1;
              bus_seq.phase = 3'd6;
            end
            3'd6: begin
              // A NACK ends here; an ACK goes on to phase 7 to release SDA.
              bus_seq.scl = 1'b0;
              if (bus_seq.nack) begin
                bus_seq.rx = bus_seq.shift;
                fin        = 1'b1;
              end else begin
                bus_seq.phase = 3'd7;
              end
            end
            default: begin
              bus_seq.sda = 1'b0;
              bus_seq.rx  = bus_seq.shift;
              fin         = 1'b1;
            end
          endcase
        end
      endcase
      if (fin) begin
        bus_seq.cmd   = CMD_IDLE;
        bus_seq.phase = 3'd0;
        bus_seq.bits  = 4'd0;
      end
    end
    pins.scl     = bus_seq.scl;
    pins.sda_low = bus_seq.sda;
    pins.busy    = (bus_seq.cmd != CMD_IDLE);
    pins.done    = fin;
    pins.rx      = bus_seq.rx;
    pins.ack     = bus_seq.ack;
    return pins;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [7:0] tx,
                                  input logic last, input logic sda, input int reps,
                                  input bit typed, input pin_result_t want);
    stim_row_t row;
    row.op    = op;
    row.tx    = tx;
    row.last  = last;
    row.sda   = sda;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Offer one beat inside the current burst and book its expected pins once taken.
  task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic last,
                           input logic sda, input bit typed, input pin_result_t want);
    int          gap;
    pin_result_t pins;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    op_i        <= op;
    tx_byte_i   <= tx;
    last_byte_i <= last;
    sda_in_i    <= sda;
    do @(posedge clk_i); while (in_stall_o);
    pins = step_bus(op, tx, last, sda);
    expected_pins.push_back(typed ? want : pins);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= ShownMisses)
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Compare every result beat taken from the block with the oldest expectation.
  always @(posedge clk_i) begin
    pin_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ShownMisses)
          $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = expected_pins.pop_front();
        check_field("scl", 8'(want.scl), 8'(scl_o));
        check_field("sda_low", 8'(want.sda_low), 8'(sda_low_o));
        check_field("busy", 8'(want.busy), 8'(busy_res_o));
        check_field("done", 8'(want.done), 8'(done_res_o));
        check_field("rx_byte", want.rx, rx_byte_o);
        check_field("acked", 8'(want.ack), 8'(acked_o));
      end
    end
  end

  // The receiver stalls in its own rhythm, and holds off for a long stretch on request.
  initial begin
    int rcv_cyc;
    rcv_cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ((rcv_cyc % 128) >= 40) && ($urandom_range(0, 2) == 0);
        rcv_cyc++;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          pick;
    logic [2:0]  op;
    bus_seq = '{cmd: CMD_IDLE, phase: 3'd0, bits: 4'd0, shift: 8'h00, nack: 1'b0,
                scl: 1'b1, sda: 1'b0, rx: 8'h00, ack: 1'b0};

    // Idle ticks and spare ops leave the reset pins; then a start, with a command
    // arriving mid-sequence; a write of all ones acked and all zeros not acked; a
    // read answered with ACK and one with NACK; and a stop.
    add_row(CMD_IDLE,   8'h00, 1'b0, 1'b0, 1,  1'b1, PinsIdleReset);
    add_row(OpSpareLo,  8'hFF, 1'b1, 1'b1, 1,  1'b1, PinsIdleReset);
    add_row(OpSpareMid, 8'h00, 1'b0, 1'b0, 1,  1'b1, PinsIdleReset);
    add_row(OpSpareHi,  8'hFF, 1'b1, 1'b1, 1,  1'b1, PinsIdleReset);
    add_row(CMD_START,  8'h00, 1'b0, 1'b1, 1,  1'b0, NoPins);
    add_row(CMD_WRITE,  8'h3C, 1'b0, 1'b1, 2,  1'b0, NoPins);
    add_row(CMD_IDLE,   8'h00, 1'b0, 1'b1, 1,  1'b1, PinsStartDone);
    add_row(CMD_WRITE,  8'hFF, 1'b0, 1'b0, 1,  1'b0, NoPins);
    add_row(CMD_IDLE,   8'h00, 1'b0, 1'b0, 27, 1'b0, NoPins);
    add_row(CMD_WRITE,  8'h00, 1'b1, 1'b1, 1,  1'b0, NoPins);
    add_row(CMD_STOP,   8'hFF, 1'b1, 1'b1, 27, 1'b0, NoPins);
    add_row(CMD_READ,   8'h00, 1'b0, 1'b1, 1,  1'b0, NoPins);
    add_row(CMD_IDLE,   8'h00, 1'b0, 1'b1, 21, 1'b0, NoPins);
    add_row(CMD_READ,   8'hFF, 1'b1, 1'b0, 1,  1'b0, NoPins);
    add_row(CMD_IDLE,   8'h00, 1'b0, 1'b0, 20, 1'b0, NoPins);
    add_row(CMD_STOP,   8'h00, 1'b0, 1'b0, 1,  1'b0, NoPins);
    add_row(CMD_IDLE,   8'h00, 1'b0, 1'b0, 4,  1'b0, NoPins);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        send_tick(directed_rows[i].op, directed_rows[i].tx, directed_rows[i].last,
                  directed_rows[i].sda, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part: mostly commands, so that the sequencer keeps running, plus plain
    // ticks and spare ops; ops that land on a busy sequencer are noise.
    for (int n = 0; n < RandomBeats; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 700) begin
        in_valid_i <= 1'b0;
        burst_left = 0;
        wait (expected_pins.size() == 0);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) op = 3'($urandom_range(CMD_START, CMD_READ));
      else if (pick < 80) op = CMD_IDLE;
      else if (pick < 90) op = 3'($urandom_range(OpSpareLo, OpSpareHi));
      else op = 3'($urandom_range(0, 7));
      send_tick(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, NoPins);
    end
    in_valid_i <= 1'b0;

    wait (expected_pins.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/i2cbb_pkg.sv
rtl/i2cbb_step.sv
rtl/i2c_bitbang_master_core.sv
tb/sv/tb_i2c_bitbang_master_core.sv
